### design/assert_macros.svh
// Assertion macros used by the line pixel generator RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent implies consequent in the same cycle
`define LPG_ASSERT_SAME(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// antecedent implies consequent in the next cycle
`define LPG_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

### design/lpg_pkg.sv
// Shared constants, types and helpers for the line pixel generator
package lpg_pkg;

    localparam int ROWS      = 64;
    localparam int COLS      = 64;
    localparam int COORD_W   = 6;
    localparam int SDELTA_W  = COORD_W + 1;
    localparam int DIV_STEPS = COORD_W;
    localparam int CNT_W     = $clog2(DIV_STEPS + 1);

    typedef logic [COORD_W-1:0]         coord_t;
    typedef logic signed [SDELTA_W-1:0] sdelta_t;

    // result of the divider: floor quotient and non-negative remainder
    typedef struct packed {
        logic    done;
        sdelta_t quot;
        coord_t  rem;
    } lpg_div_res_t;

    function automatic coord_t clamp_row(input coord_t v);
        coord_t r;
        r = v;
        if ({1'b0, v} > SDELTA_W'(ROWS - 1))
            r = COORD_W'(ROWS - 1);
        return r;
    endfunction

    function automatic coord_t clamp_col(input coord_t v);
        coord_t r;
        r = v;
        if ({1'b0, v} > SDELTA_W'(COLS - 1))
            r = COORD_W'(COLS - 1);
        return r;
    endfunction

endpackage

### design/lpg_div.sv
// Bit-serial restoring divider giving floor quotient and remainder of a signed dividend
module lpg_div (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  start,
    input  lpg_pkg::sdelta_t      dividend,
    input  lpg_pkg::coord_t       divisor,
    output lpg_pkg::lpg_div_res_t res
);

    logic                     busy_reg, busy_next;
    logic                     done_reg, done_next;
    logic [lpg_pkg::CNT_W-1:0] cnt_reg, cnt_next;
    logic                     neg_reg, neg_next;
    lpg_pkg::coord_t          quo_reg, quo_next;
    lpg_pkg::coord_t          rem_reg, rem_next;
    lpg_pkg::coord_t          dvs_reg, dvs_next;

    logic [lpg_pkg::SDELTA_W-1:0] shifted;
    logic [lpg_pkg::SDELTA_W-1:0] diff;
    logic                         ge;
    lpg_pkg::sdelta_t             mag;

    assign shifted = {rem_reg, quo_reg[lpg_pkg::COORD_W-1]};
    assign diff    = shifted - {1'b0, dvs_reg};
    assign ge      = shifted >= {1'b0, dvs_reg};
    assign mag     = dividend[lpg_pkg::SDELTA_W-1] ? -dividend : dividend;

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        neg_next  = neg_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = lpg_pkg::CNT_W'(lpg_pkg::DIV_STEPS);
            neg_next  = dividend[lpg_pkg::SDELTA_W-1];
            quo_next  = mag[lpg_pkg::COORD_W-1:0];
            rem_next  = '0;
            dvs_next  = divisor;
        end else if (busy_reg) begin
            rem_next = ge ? diff[lpg_pkg::COORD_W-1:0] : shifted[lpg_pkg::COORD_W-1:0];
            quo_next = {quo_reg[lpg_pkg::COORD_W-2:0], ge};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == lpg_pkg::CNT_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        neg_reg <= neg_next;
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    // sign restore, with floor correction for a negative dividend with nonzero remainder
    always_comb begin
        res.done = done_reg;
        res.rem  = rem_reg;
        res.quot = lpg_pkg::SDELTA_W'(quo_reg);
        if (neg_reg) begin
            if (rem_reg != '0) begin
                res.quot = -(lpg_pkg::SDELTA_W'(quo_reg) + lpg_pkg::SDELTA_W'(1));
                res.rem  = dvs_reg - rem_reg;
            end else begin
                res.quot = -lpg_pkg::SDELTA_W'(quo_reg);
            end
        end
    end

endmodule

### design/line_pixel_generator_core.sv
// Top level of the line pixel generator: request intake, step sequencer, pixel output
//
// Input channel s_*: one line request per word (two endpoints and a mark value).
// Output channel m_*: one pixel write per word; last_pixel marks the final pixel.
// A request in a single row emits every column between its endpoints, low to high.
// Any other request emits one pixel per row, top to bottom, at the floor of the
// exact rational column; coordinates past the image edge are saturated first.
// Sequence: a single-row request goes from idle straight to the emit state; every
// pixel then passes through the output register. Other requests first run a
// bit-serial divide of column span by row span, then pixels leave at one per cycle
// while m_ready allows, each found by one add and compare on the divide remainder.
// s_ready is high only while no request is being walked: a request of N pixels,
// N <= 64, occupies the block until its final pixel enters the output register.
// The output register lets a new request be accepted while the final pixel waits.
// When m_ready is low the pixel stream pauses and the held word stays unchanged.
// Reset (aresetn low, synchronous) returns to idle and drops m_valid.
`include "assert_macros.svh"

module line_pixel_generator_core (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [5:0]            s_start_row,
    input  logic [5:0]            s_start_col,
    input  logic [5:0]            s_end_row,
    input  logic [5:0]            s_end_col,
    input  logic                  s_mark_value,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [5:0]            m_pixel_row,
    output logic [5:0]            m_pixel_col,
    output logic                  m_pixel_value,
    output logic                  m_last_pixel
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_DIV  = 2'd1;
    localparam logic [1:0] ST_EMIT = 2'd2;

    logic [1:0]       state_reg, state_next;
    logic             m_valid_reg, m_valid_next;

    lpg_pkg::coord_t  row_reg, row_next;
    lpg_pkg::coord_t  col_reg, col_next;
    lpg_pkg::coord_t  end_reg, end_next;
    lpg_pkg::coord_t  den_reg, den_next;
    lpg_pkg::coord_t  rstep_reg, rstep_next;
    lpg_pkg::coord_t  rem_reg, rem_next;
    lpg_pkg::sdelta_t qstep_reg, qstep_next;
    logic             horiz_reg, horiz_next;
    logic             mark_reg, mark_next;

    lpg_pkg::coord_t  prow_reg, prow_next;
    lpg_pkg::coord_t  pcol_reg, pcol_next;
    logic             pval_reg, pval_next;
    logic             plast_reg, plast_next;

    lpg_pkg::coord_t  r1, c1, r2, c2;
    lpg_pkg::coord_t  ro1, co1, ro2, co2;
    logic             in_horiz;
    logic             accept;
    logic             div_start;
    lpg_pkg::sdelta_t div_dividend;
    lpg_pkg::coord_t  div_divisor;
    lpg_pkg::lpg_div_res_t div_res;

    logic             emit;
    logic             is_last;
    logic [lpg_pkg::SDELTA_W-1:0] rem_sum;
    logic             carry;
    logic [lpg_pkg::COORD_W+1:0]  col_step;

    assign s_ready = (state_reg == ST_IDLE);
    assign accept  = s_valid && s_ready;

    // saturate and order the endpoints
    always_comb begin
        r1       = lpg_pkg::clamp_row(s_start_row);
        c1       = lpg_pkg::clamp_col(s_start_col);
        r2       = lpg_pkg::clamp_row(s_end_row);
        c2       = lpg_pkg::clamp_col(s_end_col);
        in_horiz = (r1 == r2);
        ro1 = r1; co1 = c1; ro2 = r2; co2 = c2;
        if (in_horiz) begin
            if (c1 > c2) begin
                co1 = c2;
                co2 = c1;
            end
        end else if (r1 > r2) begin
            ro1 = r2; co1 = c2; ro2 = r1; co2 = c1;
        end
    end

    assign div_start    = accept && !in_horiz;
    assign div_dividend = lpg_pkg::SDELTA_W'(co2) - lpg_pkg::SDELTA_W'(co1);
    assign div_divisor  = ro2 - ro1;

    lpg_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .res      (div_res)
    );

    assign emit    = (state_reg == ST_EMIT) && (!m_valid_reg || m_ready);
    assign is_last = horiz_reg ? (col_reg == end_reg) : (row_reg == end_reg);
    assign rem_sum = {1'b0, rem_reg} + {1'b0, rstep_reg};
    assign carry   = rem_sum >= {1'b0, den_reg};
    assign col_step = {2'b00, col_reg} + {qstep_reg[lpg_pkg::SDELTA_W-1], qstep_reg}
                    + {{(lpg_pkg::COORD_W+1){1'b0}}, carry};

    always_comb begin
        state_next   = state_reg;
        m_valid_next = m_valid_reg;
        row_next     = row_reg;
        col_next     = col_reg;
        end_next     = end_reg;
        den_next     = den_reg;
        rstep_next   = rstep_reg;
        rem_next     = rem_reg;
        qstep_next   = qstep_reg;
        horiz_next   = horiz_reg;
        mark_next    = mark_reg;
        prow_next    = prow_reg;
        pcol_next    = pcol_reg;
        pval_next    = pval_reg;
        plast_next   = plast_reg;

        if (m_valid_reg && m_ready)
            m_valid_next = 1'b0;

        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    row_next   = ro1;
                    col_next   = co1;
                    end_next   = in_horiz ? co2 : ro2;
                    den_next   = div_divisor;
                    rem_next   = '0;
                    horiz_next = in_horiz;
                    mark_next  = s_mark_value;
                    state_next = in_horiz ? ST_EMIT : ST_DIV;
                end
            end
            ST_DIV: begin
                if (div_res.done) begin
                    qstep_next = div_res.quot;
                    rstep_next = div_res.rem;
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (emit) begin
                    m_valid_next = 1'b1;
                    prow_next    = row_reg;
                    pcol_next    = col_reg;
                    pval_next    = mark_reg;
                    plast_next   = is_last;
                    if (is_last) begin
                        state_next = ST_IDLE;
                    end else if (horiz_reg) begin
                        col_next = col_reg + 1'b1;
                    end else begin
                        row_next = row_reg + 1'b1;
                        rem_next = carry ? lpg_pkg::COORD_W'(rem_sum - {1'b0, den_reg})
                                         : rem_sum[lpg_pkg::COORD_W-1:0];
                        col_next = col_step[lpg_pkg::COORD_W-1:0];
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        row_reg   <= row_next;
        col_reg   <= col_next;
        end_reg   <= end_next;
        den_reg   <= den_next;
        rstep_reg <= rstep_next;
        rem_reg   <= rem_next;
        qstep_reg <= qstep_next;
        horiz_reg <= horiz_next;
        mark_reg  <= mark_next;
        prow_reg  <= prow_next;
        pcol_reg  <= pcol_next;
        pval_reg  <= pval_next;
        plast_reg <= plast_next;
    end

    assign m_valid       = m_valid_reg;
    assign m_pixel_row   = prow_reg;
    assign m_pixel_col   = pcol_reg;
    assign m_pixel_value = pval_reg;
    assign m_last_pixel  = plast_reg;

    `LPG_ASSERT_NEXT(a_accept_leaves_idle, aclk, aresetn, accept, state_reg != ST_IDLE, "request accepted but sequencer stayed idle")
    `LPG_ASSERT_SAME(a_div_done_in_div, aclk, aresetn, div_res.done, state_reg == ST_DIV, "divider finished outside the divide state")
    `LPG_ASSERT_SAME(a_rem_below_den, aclk, aresetn, (state_reg == ST_EMIT) && !horiz_reg, (rem_reg < den_reg) && (rstep_reg < den_reg), "step remainder not below row span")
    `LPG_ASSERT_NEXT(a_last_ends_walk, aclk, aresetn, emit && is_last, state_reg == ST_IDLE, "sequencer kept walking after final pixel")

endmodule
